[rtl/core/shf_pkg.sv]
// ----------------------------------------------------------------------------
// shf_pkg: shared types and constants of the 3x3 sharpen filter
// Register codes, stream codes, configuration widths and reset values, and
// the per-word control record that travels from the sequencer to the stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package shf_pkg;

  // Configuration register widths as seen on the register port.
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_CHAN_W   = 3;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned CFG_DATA_W   = 32;

  // Reset values of the configuration registers.
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CFG_CHAN_W-1:0]   CHAN_RESET   = 3'd3;

  // Smallest legal frame geometry.
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_MIN  = 11'd3;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN = 16'd3;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  // Input word kinds carried on tuser.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // Pixel byte width and the signed width of the stencil sum.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned SUM_W = 12;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Control record of one accepted word, registered next to the line reads.
  typedef struct packed {
    logic             emit;      // word produces an output word
    logic             interior;  // output is the filtered value, else zero
    logic             hist;      // word advances the newer-row window
    logic             frame_end; // last output word of the frame
    logic             sel;       // bank index that holds the older row
    logic [PIX_W-1:0] sample;    // incoming byte, the lower neighbor
  } item_info_t;

endpackage

`default_nettype wire

[rtl/core/shf_line_mem.sv]
// ----------------------------------------------------------------------------
// shf_line_mem: one line buffer bank
// Synchronous memory with one write port and two read ports; read data is
// registered and held while the read enable is low. A read and a write of the
// same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_line_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [shf_pkg::PIX_W-1:0]  wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr0,
  input  wire logic [AW-1:0]              raddr1,
  output logic      [shf_pkg::PIX_W-1:0]  q0,
  output logic      [shf_pkg::PIX_W-1:0]  q1
);

  logic [shf_pkg::PIX_W-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      q0 <= mem_r[raddr0];
      q1 <= mem_r[raddr1];
    end
  end

endmodule

`default_nettype wire

[rtl/core/shf_ctrl.sv]
// ----------------------------------------------------------------------------
// shf_ctrl: raster sequencer of the sharpen filter
// Tracks the byte and row position, the drain phase and which bank holds the
// older row. For each accepted word it produces the line buffer addresses,
// the write strobe and the control record for the stencil stage.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_ctrl #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned AW           = 12,
  parameter int unsigned HIW          = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic                              mode,
  input  wire logic [shf_pkg::PIX_W-1:0]         sample,
  input  wire logic [shf_pkg::CFG_WIDTH_W-1:0]   cfg_width,
  input  wire logic [shf_pkg::CFG_HEIGHT_W-1:0]  cfg_height,
  input  wire logic [shf_pkg::CFG_CHAN_W-1:0]    cfg_chan,
  output shf_pkg::item_info_t                    info,
  output logic                                   wr_en,
  output logic      [AW-1:0]                     addr_center,
  output logic      [AW-1:0]                     addr_right,
  output logic      [AW-1:0]                     addr_left,
  output logic                                   sel,
  output logic      [HIW-1:0]                    cidx
);

  localparam int unsigned BUF = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned EW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned LW  = $clog2(BUF + 1);
  localparam int unsigned SW  = LW + 1;
  localparam int unsigned RW  = shf_pkg::CFG_HEIGHT_W;

  logic [AW-1:0] byte_r, byte_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          drain_r, drain_nxt;
  logic          sel_r, sel_nxt;

  logic [EW-1:0] eff_w;
  logic [CW-1:0] eff_c;
  logic [RW-1:0] eff_h;
  logic [LW-1:0] row_len;
  logic [SW-1:0] b_ext;
  logic          byte_last;
  logic          row_last;
  logic          is_sample;

  // Clamp the geometry registers to the supported range.
  always_comb begin
    if (cfg_width < shf_pkg::WIDTH_MIN) begin
      eff_w = EW'(shf_pkg::WIDTH_MIN);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_width);
    end
    if (cfg_chan == '0) begin
      eff_c = CW'(1);
    end else if (32'(cfg_chan) > MAX_CHANNELS) begin
      eff_c = CW'(MAX_CHANNELS);
    end else begin
      eff_c = CW'(cfg_chan);
    end
    eff_h = (cfg_height < shf_pkg::HEIGHT_MIN) ? shf_pkg::HEIGHT_MIN : cfg_height;
  end

  // Row length in bytes and position tests.
  assign row_len   = LW'(eff_w) * LW'(eff_c);
  assign b_ext     = SW'(byte_r);
  assign byte_last = (b_ext + SW'(1)) >= SW'(row_len);
  assign row_last  = ({1'b0, row_r} + (RW+1)'(1)) >= {1'b0, eff_h};
  assign is_sample = !drain_r && (mode == shf_pkg::MODE_SAMPLE);

  // Control record of the word being accepted.
  always_comb begin
    info           = '0;
    info.sel       = sel_r;
    info.sample    = sample;
    if (drain_r) begin
      info.emit      = (mode == shf_pkg::MODE_DRAIN);
      info.frame_end = byte_last;
    end else if (mode == shf_pkg::MODE_SAMPLE) begin
      info.emit     = (row_r != '0);
      info.hist     = 1'b1;
      info.interior = (row_r >= RW'(2)) && (b_ext >= SW'(eff_c))
                   && ((b_ext + SW'(eff_c)) < SW'(row_len));
    end
  end

  // Line buffer addressing: older row at the byte, newer row one pixel
  // right and one pixel left of it.
  assign addr_center = byte_r;
  assign addr_right  = byte_r + AW'(eff_c);
  assign addr_left   = byte_r - AW'(eff_c);
  assign wr_en       = accept && is_sample;
  assign sel         = sel_r;
  assign cidx        = HIW'(eff_c - CW'(1));

  // Position update on each accepted sample word, or drain word in the drain phase.
  always_comb begin
    byte_nxt  = byte_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    sel_nxt   = sel_r;
    if (accept) begin
      if (drain_r) begin
        if (mode == shf_pkg::MODE_DRAIN) begin
          if (byte_last) begin
            drain_nxt = 1'b0;
            row_nxt   = '0;
            byte_nxt  = '0;
          end else begin
            byte_nxt = byte_r + AW'(1);
          end
        end
      end else if (mode == shf_pkg::MODE_SAMPLE) begin
        if (byte_last) begin
          sel_nxt  = !sel_r;
          byte_nxt = '0;
          if (row_last) begin
            drain_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          byte_nxt = byte_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      byte_r  <= byte_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/shf_stencil.sv]
// ----------------------------------------------------------------------------
// shf_stencil: stencil stage and output register of the sharpen filter
// Holds the control record next to the registered line reads, keeps a short
// window of the newer row for the centre tap, forms 5*centre minus the four
// neighbors, saturates it and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_stencil #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned HIW          = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire shf_pkg::item_info_t         info_in,
  input  wire logic [HIW-1:0]              cidx,
  input  wire logic [shf_pkg::PIX_W-1:0]   bank0_q0,
  input  wire logic [shf_pkg::PIX_W-1:0]   bank0_q1,
  input  wire logic [shf_pkg::PIX_W-1:0]   bank1_q0,
  input  wire logic [shf_pkg::PIX_W-1:0]   bank1_q1,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [shf_pkg::PIX_W-1:0]   out_value,
  output logic                             out_last
);

  localparam int unsigned PW = shf_pkg::PIX_W;
  localparam int unsigned SW = shf_pkg::SUM_W;

  shf_pkg::item_info_t s1_info_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_go;

  logic [PW-1:0] hist_r [MAX_CHANNELS];

  logic [PW-1:0]        older_q, right_q, left_q, center_q;
  logic signed [SW-1:0] sum;
  logic [PW-1:0]        value;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_value_r;
  logic          out_last_r;

  // Stage handshake: a word leaves when it emits nothing or the output
  // register is free or being drained this cycle.
  assign s1_go        = s1_valid_r && (!s1_info_r.emit || !out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_go;
  assign s1_valid_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info_in;
    end
  end

  // Route the bank reads by the bank that held the older row.
  always_comb begin
    if (s1_info_r.sel) begin
      older_q = bank1_q0;
      right_q = bank0_q0;
      left_q  = bank0_q1;
    end else begin
      older_q = bank0_q0;
      right_q = bank1_q0;
      left_q  = bank1_q1;
    end
  end

  // The centre byte was read as the right neighbor one pixel earlier.
  always_ff @(posedge clk) begin
    if (s1_go && s1_info_r.hist) begin
      hist_r[0] <= right_q;
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  assign center_q = hist_r[cidx];

  // Five times the centre minus the four neighbors, saturated to a byte.
  always_comb begin
    sum = $signed(SW'({center_q, 2'b00}) + SW'(center_q))
        - $signed(SW'(left_q)) - $signed(SW'(right_q))
        - $signed(SW'(older_q)) - $signed(SW'(s1_info_r.sample));
    if (!s1_info_r.interior || sum[SW-1]) begin
      value = '0;
    end else if (sum > $signed(SW'(shf_pkg::PIX_MAX))) begin
      value = shf_pkg::PIX_MAX;
    end else begin
      value = sum[PW-1:0];
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_info_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_info_r.emit) begin
      out_value_r <= value;
      out_last_r  <= s1_info_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/sharpen_filter_3x3.sv]
// ----------------------------------------------------------------------------
// sharpen_filter_3x3: streaming 3x3 Laplacian sharpen over interleaved bytes
// Two ping-pong line buffer banks hold the two previous rows; output row r-1
// is produced while input row r arrives, with zero borders, and drain words
// emit the final row and mark the last byte of the frame.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents                      Accepted when
//  in_*     input      tdata: sample, tuser: mode         in_tvalid & in_tready
//  out_*    output     tdata: value, tlast: frame_end     out_tvalid & out_tready
//  cfg_*    input      width, height, channel count       psel & penable & pwrite
//
// One word is accepted per clock while the output is not stalled. The line
// buffer read registers a word's taps and control record at its accepting
// edge; the stencil works on them and loads the output register, so a result
// is offered from the output register once its input word has left that stage.
// Each bank takes one write and two reads per cycle; no clearing pass is run
// after reset.
// A stalled output holds the stencil stage, which in turn holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_filter_3x3 #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] sample
  input  wire logic                              in_tuser,   // [0] mode
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [7:0]                        out_tdata,  // [7:0] value
  output logic                                   out_tlast,
  // Register port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [shf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [shf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [shf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int unsigned BUF = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW  = $clog2(BUF);
  localparam int unsigned HIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [shf_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [shf_pkg::CFG_HEIGHT_W-1:0] height_r;
  logic [shf_pkg::CFG_CHAN_W-1:0]   chan_r;
  logic                             cfg_wr;
  shf_pkg::cfg_reg_e                cfg_idx;

  logic                accept;
  shf_pkg::item_info_t info;
  logic                wr_en;
  logic [AW-1:0]       addr_center, addr_right, addr_left;
  logic                sel;
  logic [HIW-1:0]      cidx;

  logic [AW-1:0] b0_raddr0, b1_raddr0;
  logic [7:0]    b0_q0, b0_q1, b1_q0, b1_q1;

  // Register port: writes on the access phase, reads return the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = shf_pkg::cfg_reg_e'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= shf_pkg::WIDTH_RESET;
      height_r <= shf_pkg::HEIGHT_RESET;
      chan_r   <= shf_pkg::CHAN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        shf_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_pwdata[shf_pkg::CFG_WIDTH_W-1:0];
        shf_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_pwdata[shf_pkg::CFG_HEIGHT_W-1:0];
        shf_pkg::REG_CHANNEL_COUNT: chan_r   <= cfg_pwdata[shf_pkg::CFG_CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      shf_pkg::REG_IMAGE_WIDTH:   cfg_prdata = shf_pkg::CFG_DATA_W'(width_r);
      shf_pkg::REG_IMAGE_HEIGHT:  cfg_prdata = shf_pkg::CFG_DATA_W'(height_r);
      shf_pkg::REG_CHANNEL_COUNT: cfg_prdata = shf_pkg::CFG_DATA_W'(chan_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // Raster sequencer.
  shf_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .HIW          (HIW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_tuser),
    .sample      (in_tdata),
    .cfg_width   (width_r),
    .cfg_height  (height_r),
    .cfg_chan    (chan_r),
    .info        (info),
    .wr_en       (wr_en),
    .addr_center (addr_center),
    .addr_right  (addr_right),
    .addr_left   (addr_left),
    .sel         (sel),
    .cidx        (cidx)
  );

  // The older bank is read and written at the byte; the newer bank is read
  // one pixel to either side.
  assign b0_raddr0 = sel ? addr_right  : addr_center;
  assign b1_raddr0 = sel ? addr_center : addr_right;

  shf_line_mem #(
    .DEPTH (BUF),
    .AW    (AW)
  ) u_bank0 (
    .clk    (clk),
    .we     (wr_en && !sel),
    .waddr  (addr_center),
    .wdata  (in_tdata),
    .re     (accept),
    .raddr0 (b0_raddr0),
    .raddr1 (addr_left),
    .q0     (b0_q0),
    .q1     (b0_q1)
  );

  shf_line_mem #(
    .DEPTH (BUF),
    .AW    (AW)
  ) u_bank1 (
    .clk    (clk),
    .we     (wr_en && sel),
    .waddr  (addr_center),
    .wdata  (in_tdata),
    .re     (accept),
    .raddr0 (b1_raddr0),
    .raddr1 (addr_left),
    .q0     (b1_q0),
    .q1     (b1_q1)
  );

  // Stencil stage and output register.
  shf_stencil #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .HIW          (HIW)
  ) u_stencil (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .info_in   (info),
    .cidx      (cidx),
    .bank0_q0  (b0_q0),
    .bank0_q1  (b0_q1),
    .bank1_q0  (b1_q0),
    .bank1_q1  (b1_q1),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
